// File: rtl/gfs_pkg.sv
// Shared constants and the Gaussian lookup table of the formant shaper.
// Used by every other source file of the project; depends on nothing else.
package gfs_pkg;

    localparam int MAX_FORMANTS_DEF  = 4;
    localparam int HARMONIC_BITS_DEF = 10;

    localparam int FREQ_BITS = 24;   // Q16.8 frequencies and widths
    localparam int AMP_BITS  = 32;   // Q16.16 amplitudes
    localparam int WORD_BITS = 64;   // packed formant word
    localparam int GAIN_BITS = 16;   // Q4.12 gain
    localparam int AX_BITS   = 11;   // |x| in Q3.8, below 8.0
    localparam int DIV_STEPS = 2;    // quotient bits resolved per pipeline stage
    localparam int REM_BITS  = FREQ_BITS + AX_BITS;
    localparam int DIV_STAGES = (AX_BITS + DIV_STEPS - 1) / DIV_STEPS;

    // Register indices of the configuration port.
    localparam int REG_FORMANT_COUNT = 0;
    localparam int REG_FORMANT_WORD0 = 1;
    // The register map holds at most four formant words, one per slot that exists.
    localparam int WORD_REGS        = 4;
    localparam int CFG_INDEX_BITS   = 3;

    // exp(-k*k/32) in Q1.16, k in quarter steps of |x|.
    function automatic logic [16:0] gauss_tab(input logic [5:0] k);
        logic [16:0] t;
        unique case (k)
            6'd0:    t = 17'd65536;
            6'd1:    t = 17'd63520;
            6'd2:    t = 17'd57835;
            6'd3:    t = 17'd49469;
            6'd4:    t = 17'd39750;
            6'd5:    t = 17'd30005;
            6'd6:    t = 17'd21276;
            6'd7:    t = 17'd14173;
            6'd8:    t = 17'd8869;
            6'd9:    t = 17'd5214;
            6'd10:   t = 17'd2879;
            6'd11:   t = 17'd1494;
            6'd12:   t = 17'd728;
            6'd13:   t = 17'd333;
            6'd14:   t = 17'd143;
            6'd15:   t = 17'd58;
            6'd16:   t = 17'd22;
            6'd17:   t = 17'd8;
            6'd18:   t = 17'd3;
            6'd19:   t = 17'd1;
            default: t = 17'd0;
        endcase
        return t;
    endfunction

endpackage

// File: rtl/gfs_formant.sv
// One formant of the shaper as a fixed-latency pipeline with a common stall enable.
// Depends on gfs_pkg for formats, the divider split and the Gaussian table.
module gfs_formant #(
    parameter int HARMONIC_BITS = gfs_pkg::HARMONIC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              active,
    input  logic [gfs_pkg::WORD_BITS-1:0]     word,
    input  logic                              in_valid,
    input  logic [HARMONIC_BITS-1:0]          in_idx,
    input  logic [HARMONIC_BITS+gfs_pkg::FREQ_BITS-1:0] in_pos,
    input  logic signed [gfs_pkg::AMP_BITS-1:0] in_amp,
    output logic                              out_valid,
    output logic [HARMONIC_BITS-1:0]          out_idx,
    output logic [HARMONIC_BITS+gfs_pkg::FREQ_BITS-1:0] out_pos,
    output logic signed [gfs_pkg::AMP_BITS-1:0] out_amp
);
    localparam int PW = HARMONIC_BITS + gfs_pkg::FREQ_BITS;
    localparam int FB = gfs_pkg::FREQ_BITS;
    localparam int RB = gfs_pkg::REM_BITS;
    localparam int QB = gfs_pkg::AX_BITS;
    localparam int DS = gfs_pkg::DIV_STAGES;
    localparam int GB = gfs_pkg::GAIN_BITS;
    localparam int AB = gfs_pkg::AMP_BITS;

    // Stage 1: distance from the centre.
    logic                 v1_reg;
    logic [HARMONIC_BITS-1:0] idx1_reg;
    logic [PW-1:0]        pos1_reg, d1_reg, d1_next;
    logic signed [AB-1:0] amp1_reg;
    logic [FB-1:0]        w1_reg, w1_next;
    logic [GB-1:0]        g1_reg;

    always_comb begin
        logic [PW-1:0] c;
        c = PW'(word[63:40]);
        d1_next = (in_pos >= c) ? in_pos - c : c - in_pos;
        w1_next = (word[39:16] == '0) ? FB'(256) : word[39:16];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
        if (en) begin
            idx1_reg <= in_idx;
            pos1_reg <= in_pos;
            amp1_reg <= in_amp;
            d1_reg   <= d1_next;
            w1_reg   <= w1_next;
            g1_reg   <= word[GB-1:0];
        end
    end

    // Division stages; entry 0 holds the range check and the numerator.
    logic                 v_reg   [0:DS];
    logic [HARMONIC_BITS-1:0] idx_reg [0:DS];
    logic [PW-1:0]        pos_reg [0:DS];
    logic signed [AB-1:0] amp_reg [0:DS];
    logic [FB-1:0]        w_reg   [0:DS];
    logic [GB-1:0]        g_reg   [0:DS];
    logic                 far_reg [0:DS];
    logic [RB-1:0]        rem_reg [0:DS];
    logic [QB-1:0]        q_reg   [0:DS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= v1_reg;
        end
        if (en) begin
            idx_reg[0] <= idx1_reg;
            pos_reg[0] <= pos1_reg;
            amp_reg[0] <= amp1_reg;
            w_reg[0]   <= w1_reg;
            g_reg[0]   <= g1_reg;
            // At or beyond eight widths the Gaussian is zero and the quotient is unused.
            far_reg[0] <= d1_reg >= PW'({w1_reg, 3'b000});
            rem_reg[0] <= {d1_reg[RB-9:0], 8'h00};
            q_reg[0]   <= '0;
        end
    end

    for (genvar j = 1; j <= DS; j++) begin : g_div
        logic [RB-1:0] rem_next;
        logic [QB-1:0] q_next;

        always_comb begin
            int b;
            rem_next = rem_reg[j-1];
            q_next   = q_reg[j-1];
            for (int s = 0; s < gfs_pkg::DIV_STEPS; s++) begin
                b = QB - 1 - ((j - 1) * gfs_pkg::DIV_STEPS + s);
                if (b >= 0) begin
                    if (rem_next >= (RB'(w_reg[j-1]) << b)) begin
                        rem_next = rem_next - (RB'(w_reg[j-1]) << b);
                        q_next[b] = 1'b1;
                    end
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[j] <= 1'b0;
            end else if (en) begin
                v_reg[j] <= v_reg[j-1];
            end
            if (en) begin
                idx_reg[j] <= idx_reg[j-1];
                pos_reg[j] <= pos_reg[j-1];
                amp_reg[j] <= amp_reg[j-1];
                w_reg[j]   <= w_reg[j-1];
                g_reg[j]   <= g_reg[j-1];
                far_reg[j] <= far_reg[j-1];
                rem_reg[j] <= rem_next;
                q_reg[j]   <= q_next;
            end
        end
    end

    // Gaussian by table lookup and linear interpolation.
    logic                 vg_reg;
    logic [HARMONIC_BITS-1:0] idxg_reg;
    logic [PW-1:0]        posg_reg;
    logic signed [AB-1:0] ampg_reg;
    logic [GB-1:0]        gg_reg;
    logic [16:0]          gauss_reg, gauss_next;

    always_comb begin
        logic [16:0] hi, lo;
        logic [22:0] step;
        hi   = gfs_pkg::gauss_tab({1'b0, q_reg[DS][QB-1:6]});
        lo   = gfs_pkg::gauss_tab(6'({1'b0, q_reg[DS][QB-1:6]}) + 6'd1);
        step = 23'(hi - lo) * 23'(q_reg[DS][5:0]);
        gauss_next = far_reg[DS] ? 17'd0 : hi - step[22:6];
    end

    // Factor 1 + gain * G in signed Q.28.
    logic                 vf_reg;
    logic [HARMONIC_BITS-1:0] idxf_reg;
    logic [PW-1:0]        posf_reg;
    logic signed [AB-1:0] ampf_reg;
    logic signed [33:0]   factor_reg, factor_next;

    assign factor_next = 34'sd268435456
        + $signed({{18{gg_reg[GB-1]}}, gg_reg}) * $signed({17'd0, gauss_reg});

    // Product of amplitude and factor.
    logic                 vp_reg;
    logic [HARMONIC_BITS-1:0] idxp_reg;
    logic [PW-1:0]        posp_reg;
    logic signed [AB-1:0] ampp_reg;
    logic signed [65:0]   prod_reg, prod_next;

    assign prod_next = $signed({{34{ampf_reg[AB-1]}}, ampf_reg})
                     * $signed({{32{factor_reg[33]}}, factor_reg});

    // Truncate toward zero, saturate, or pass through when the formant is unused.
    logic                 vo_reg;
    logic [HARMONIC_BITS-1:0] idxo_reg;
    logic [PW-1:0]        poso_reg;
    logic signed [AB-1:0] ampo_reg, ampo_next;

    always_comb begin
        logic signed [65:0] adj, sh;
        adj = prod_reg + (prod_reg[65] ? 66'sd268435455 : 66'sd0);
        sh  = adj >>> 28;
        if (!active) begin
            ampo_next = ampp_reg;
        end else if (sh > 66'sd2147483647) begin
            ampo_next = 32'sh7FFFFFFF;
        end else if (sh < -66'sd2147483648) begin
            ampo_next = 32'sh80000000;
        end else begin
            ampo_next = sh[AB-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vg_reg <= 1'b0;
            vf_reg <= 1'b0;
            vp_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else if (en) begin
            vg_reg <= v_reg[DS];
            vf_reg <= vg_reg;
            vp_reg <= vf_reg;
            vo_reg <= vp_reg;
        end
        if (en) begin
            idxg_reg   <= idx_reg[DS];
            posg_reg   <= pos_reg[DS];
            ampg_reg   <= amp_reg[DS];
            gg_reg     <= g_reg[DS];
            gauss_reg  <= gauss_next;
            idxf_reg   <= idxg_reg;
            posf_reg   <= posg_reg;
            ampf_reg   <= ampg_reg;
            factor_reg <= factor_next;
            idxp_reg   <= idxf_reg;
            posp_reg   <= posf_reg;
            ampp_reg   <= ampf_reg;
            prod_reg   <= prod_next;
            idxo_reg   <= idxp_reg;
            poso_reg   <= posp_reg;
            ampo_reg   <= ampo_next;
        end
    end

    assign out_valid = vo_reg;
    assign out_idx   = idxo_reg;
    assign out_pos   = poso_reg;
    assign out_amp   = ampo_reg;

endmodule

// File: rtl/gaussian_formant_shaper.sv
// Each item passes the input register and then the pipeline of every formant in turn.
// Throughput: one item per cycle unless the output stalls; every formant has its own 12-stage
// pipeline and the divider resolves two quotient bits per stage. The pipeline stalls as a whole
// while a result waits at the output register. Reset (aresetn, synchronous, active low) clears
// the valid bits, the formant count and the formant words.
module gaussian_formant_shaper #(
    parameter int MAX_FORMANTS  = gfs_pkg::MAX_FORMANTS_DEF,
    parameter int HARMONIC_BITS = gfs_pkg::HARMONIC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [gfs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [gfs_pkg::WORD_BITS-1:0]     cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [HARMONIC_BITS-1:0]          s_harmonic_index,
    input  logic [gfs_pkg::FREQ_BITS-1:0]     s_fundamental_hz,
    input  logic signed [gfs_pkg::AMP_BITS-1:0] s_amplitude,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [HARMONIC_BITS-1:0]          m_harmonic_number,
    output logic signed [gfs_pkg::AMP_BITS-1:0] m_shaped_amplitude
);
    localparam int IW = gfs_pkg::CFG_INDEX_BITS;
    localparam int PW = HARMONIC_BITS + gfs_pkg::FREQ_BITS;

    logic [2:0]                    count_reg;
    logic [gfs_pkg::WORD_BITS-1:0] word_reg [0:MAX_FORMANTS-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            for (int i = 0; i < MAX_FORMANTS; i++) begin
                word_reg[i] <= '0;
            end
        end else if (cfg_we) begin
            if (cfg_index == IW'(gfs_pkg::REG_FORMANT_COUNT)) begin
                count_reg <= cfg_data[2:0];
            end
            for (int i = 0; i < MAX_FORMANTS; i++) begin
                if (i < gfs_pkg::WORD_REGS
                        && cfg_index == IW'(gfs_pkg::REG_FORMANT_WORD0 + i)) begin
                    word_reg[i] <= cfg_data;
                end
            end
        end
    end

    logic en;
    assign en      = m_ready || !m_valid;
    assign s_ready = en;

    // Input stage: harmonic frequency index * f in Q.8.
    logic                 v_reg   [0:MAX_FORMANTS];
    logic [HARMONIC_BITS-1:0] idx_reg [0:MAX_FORMANTS];
    logic [PW-1:0]        pos_reg [0:MAX_FORMANTS];
    logic signed [gfs_pkg::AMP_BITS-1:0] amp_reg [0:MAX_FORMANTS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= s_valid;
        end
        if (en) begin
            idx_reg[0] <= s_harmonic_index;
            pos_reg[0] <= PW'(s_harmonic_index) * PW'(s_fundamental_hz);
            amp_reg[0] <= s_amplitude;
        end
    end

    for (genvar k = 0; k < MAX_FORMANTS; k++) begin : g_formant
        logic active;
        // A count above the number of formant slots behaves as all slots in use.
        assign active = 32'(count_reg) > k;

        gfs_formant #(
            .HARMONIC_BITS(HARMONIC_BITS)
        ) u_formant (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .active    (active),
            .word      (word_reg[k]),
            .in_valid  (v_reg[k]),
            .in_idx    (idx_reg[k]),
            .in_pos    (pos_reg[k]),
            .in_amp    (amp_reg[k]),
            .out_valid (v_reg[k+1]),
            .out_idx   (idx_reg[k+1]),
            .out_pos   (pos_reg[k+1]),
            .out_amp   (amp_reg[k+1])
        );
    end

    assign m_valid            = v_reg[MAX_FORMANTS];
    assign m_harmonic_number  = idx_reg[MAX_FORMANTS];
    assign m_shaped_amplitude = amp_reg[MAX_FORMANTS];

endmodule

// File: rtl/gfs_checker.sv
// Port-level checks of the formant shaper and the bind that attaches them.
// Depends on gaussian_formant_shaper and gfs_pkg.
module gfs_checker #(
    parameter int HARMONIC_BITS = gfs_pkg::HARMONIC_BITS_DEF
) (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [HARMONIC_BITS-1:0]          m_harmonic_number,
    input logic signed [gfs_pkg::AMP_BITS-1:0] m_shaped_amplitude
);

    // The input side stalls exactly when a result waits to be transferred.
    a_ready_follows_output: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (m_ready || !m_valid))
        else $error("s_ready does not follow the output stall");

    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_shaped_amplitude)
            && $stable(m_harmonic_number))
        else $error("stalled result changed");

    a_no_result_from_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(m_valid) |-> $past(m_ready) || !$past(aresetn))
        else $error("result dropped without transfer");

endmodule

bind gaussian_formant_shaper gfs_checker #(.HARMONIC_BITS(HARMONIC_BITS)) u_gfs_checker (.*);

// File: tb/sv/gaussian_formant_shaper_tb.sv
// Self-checking testbench for gaussian_formant_shaper: a predictor of the formant
// factors, random stimulus and random output back-pressure. Depends on rtl/gfs_pkg.sv.
`timescale 1ns / 1ps

module gaussian_formant_shaper_tb;

    localparam int NFORM   = gfs_pkg::MAX_FORMANTS_DEF;
    localparam int HBITS   = gfs_pkg::HARMONIC_BITS_DEF;
    localparam int IDXW    = gfs_pkg::CFG_INDEX_BITS;
    localparam int AW      = gfs_pkg::AMP_BITS;
    localparam int FW      = gfs_pkg::FREQ_BITS;
    localparam int WW      = gfs_pkg::WORD_BITS;
    localparam int LATENCY = 1 + 12 * NFORM;
    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        logic [HBITS-1:0]     number;
        logic signed [AW-1:0] amp;
    } shaped_t;

    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        cfg_we = 1'b0;
    logic [IDXW-1:0]             cfg_index = '0;
    logic [WW-1:0]               cfg_data = '0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic [HBITS-1:0]            s_harmonic_index = '0;
    logic [FW-1:0]               s_fundamental_hz = '0;
    logic signed [AW-1:0]        s_amplitude = '0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic [HBITS-1:0]            m_harmonic_number;
    logic signed [AW-1:0]        m_shaped_amplitude;

    // Own copy of the configuration.
    logic [2:0]                  count_shadow;
    logic [WW-1:0]               word_shadow [NFORM];

    shaped_t                     shaped_q[$];
    int                          errors = 0;
    bit                          gaps_on = 1'b1;
    int                          stall_cycles = 0;

    const int unsigned gauss_lut [33] = '{
        65536, 63520, 57835, 49469, 39750, 30005, 21276, 14173,
        8869, 5214, 2879, 1494, 728, 333, 143, 58,
        22, 8, 3, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};

    gaussian_formant_shaper dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_harmonic_index(s_harmonic_index), .s_fundamental_hz(s_fundamental_hz),
        .s_amplitude(s_amplitude),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_harmonic_number(m_harmonic_number), .m_shaped_amplitude(m_shaped_amplitude)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint unsigned gauss_of(longint unsigned ax);
        int unsigned k, frac, hi, lo;
        if (ax >= 2048) return 0;
        k = int'(ax >> 6);
        frac = int'(ax & 63);
        hi = gauss_lut[k];
        lo = gauss_lut[k + 1];
        return hi - (((hi - lo) * frac) >> 6);
    endfunction

    function automatic logic signed [AW-1:0] shape_amplitude(
            logic [HBITS-1:0] idx, logic [FW-1:0] f, logic signed [AW-1:0] a);
        longint amp, gain, factor, prod, q;
        longint unsigned pos, centre, width, offset, ax;
        int n;
        amp = a;
        pos = longint'(idx) * longint'(f);
        n = (count_shadow > NFORM) ? NFORM : count_shadow;
        for (int k = 0; k < n; k++) begin
            centre = word_shadow[k][63:40];
            width  = word_shadow[k][39:16];
            gain   = longint'($signed(word_shadow[k][15:0]));
            if (width == 0) width = 256;
            offset = (pos >= centre) ? pos - centre : centre - pos;
            ax = (offset << 8) / width;
            factor = (longint'(1) << 28) + gain * longint'(gauss_of(ax));
            prod = amp * factor;
            q = (prod < 0) ? -((-prod) >>> 28) : (prod >>> 28);
            if (q > 64'sd2147483647) q = 64'sd2147483647;
            if (q < -64'sd2147483648) q = -64'sd2147483648;
            amp = q;
        end
        return amp[31:0];
    endfunction

    task automatic write_reg(int idx, logic [WW-1:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= IDXW'(idx);
        cfg_data  <= value;
        if (idx == gfs_pkg::REG_FORMANT_COUNT) count_shadow = value[2:0];
        else if (idx - gfs_pkg::REG_FORMANT_WORD0 < NFORM)
            word_shadow[idx - gfs_pkg::REG_FORMANT_WORD0] = value;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (shaped_q.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    task automatic send_harmonic(logic [HBITS-1:0] idx, logic [FW-1:0] f,
                                 logic signed [AW-1:0] a);
        int gap;
        s_valid          <= 1'b1;
        s_harmonic_index <= idx;
        s_fundamental_hz <= f;
        s_amplitude      <= a;
        do @(posedge aclk); while (!(s_valid && s_ready));
        gap = (gaps_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 14) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    function automatic logic [WW-1:0] pack_formant(int unsigned centre,
            int unsigned width, int unsigned gain);
        return {centre[23:0], width[23:0], gain[15:0]};
    endfunction

    // Mostly harmonics that land near one of the formant centres, the rest anything.
    task automatic send_random(int num);
        logic [HBITS-1:0] idx;
        logic [FW-1:0] f;
        longint unsigned centre;
        int k;
        for (int i = 0; i < num; i++) begin
            idx = $urandom_range(0, 3) == 0 ? HBITS'($urandom) : HBITS'($urandom_range(1, 40));
            if ($urandom_range(0, 3) != 0 && idx != 0) begin
                k = $urandom_range(0, NFORM - 1);
                centre = word_shadow[k][63:40];
                f = FW'(centre / idx + $urandom_range(0, 2048) - 1024);
            end else begin
                f = FW'($urandom);
            end
            send_harmonic(idx, f, $urandom_range(0, 7) == 0 ?
                          ($urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000) : $urandom);
        end
        s_valid <= 1'b0;
    endtask

    task automatic random_formants(int count);
        for (int k = 0; k < NFORM; k++)
            write_reg(gfs_pkg::REG_FORMANT_WORD0 + k, pack_formant($urandom,
                      $urandom_range(0, 3) == 0 ? $urandom_range(0, 3) : $urandom_range(0, 65535),
                      $urandom));
        write_reg(gfs_pkg::REG_FORMANT_COUNT, count);
    endtask

    task automatic test_passthrough();
        send_harmonic(10'd1, 24'd1, 32'sh7fffffff);
        send_harmonic('1, '1, 32'sh80000000);
        send_random(100);
        drain();
    endtask

    task automatic test_directed_extremes();
        // Centre at 440 Hz, width 1 Hz, full positive gain then full negative gain.
        write_reg(gfs_pkg::REG_FORMANT_WORD0, pack_formant(440 * 256, 256, 16'h7fff));
        write_reg(gfs_pkg::REG_FORMANT_WORD0 + 1, pack_formant(440 * 256, 0, 16'h8000));
        write_reg(gfs_pkg::REG_FORMANT_WORD0 + 2, pack_formant(0, 0, 16'h7fff));
        write_reg(gfs_pkg::REG_FORMANT_WORD0 + 3, '1);
        write_reg(gfs_pkg::REG_FORMANT_COUNT, 1);
        send_harmonic(10'd1, 24'd440 * 256, 32'sh7fffffff);      // saturates high
        send_harmonic(10'd1, 24'd440 * 256, 32'sh80000000);      // saturates low
        send_harmonic(10'd2, 24'd220 * 256 + 24'd40, 32'sh00010000);
        send_harmonic(10'd1, 24'd440 * 256 + 24'd2047, 32'sh00010000);
        send_harmonic(10'd1, 24'd440 * 256 + 24'd2048, -32'sh00012345);
        s_valid <= 1'b0;
        drain();
        write_reg(gfs_pkg::REG_FORMANT_COUNT, 2);
        send_harmonic(10'd1, 24'd440 * 256, 32'sh00010000);
        send_harmonic(10'd1, 24'd440 * 256 + 24'd100, -32'sh00010000);
        s_valid <= 1'b0;
        drain();
        write_reg(gfs_pkg::REG_FORMANT_COUNT, 7);                 // clamps to the maximum
        send_harmonic(10'd0, 24'd12345, 32'sh00010000);           // zero index
        send_harmonic(10'd5, 24'd0, -32'sh7fffffff);              // zero fundamental
        send_harmonic('1, '1, 32'sh7fffffff);
        send_harmonic(10'd1, 24'd1, 32'sh80000000);
        send_harmonic(10'h2aa, 24'h555555, 32'sh55555555);
        send_harmonic(10'h155, 24'haaaaaa, 32'shaaaaaaaa);
        s_valid <= 1'b0;
        drain();
    endtask

    task automatic test_ignored_writes();
        // Indexes past the last formant word must leave the configuration alone.
        for (int i = NFORM + 1; i < (1 << IDXW); i++) write_reg(i, '1);
        send_random(100);
        drain();
    endtask

    task automatic test_random_settings();
        int counts [5] = '{4, 1, 3, 7, 2};
        foreach (counts[i]) begin
            random_formants(counts[i]);
            send_random(300);
            drain();
        end
    endtask

    task automatic test_full_rate();
        gaps_on = 1'b0;
        random_formants(4);
        send_random(300);
        drain();
    endtask

    // Output back-pressure in random bursts.
    int stall_left = 0;
    always @(posedge aclk) begin
        if (gaps_on && stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            if (gaps_on && $urandom_range(0, 7) == 0) stall_left <= $urandom_range(1, 14);
        end
    end

    // Expectations are formed at input transfer; results are checked in order.
    always @(posedge aclk) begin
        shaped_t want;
        if (aresetn && s_valid && s_ready)
            shaped_q.push_back(shaped_t'{s_harmonic_index,
                shape_amplitude(s_harmonic_index, s_fundamental_hz, s_amplitude)});
        if (aresetn && m_valid && m_ready) begin
            if (shaped_q.size() == 0) begin
                $display("%0t: result with nothing expected: number %0d amplitude %0d",
                         $time, m_harmonic_number, m_shaped_amplitude);
                errors++;
            end else begin
                want = shaped_q.pop_front();
                if (m_harmonic_number !== want.number) begin
                    $display("%0t: harmonic number expected %0d actual %0d",
                             $time, want.number, m_harmonic_number);
                    errors++;
                end
                if (m_shaped_amplitude !== want.amp) begin
                    $display("%0t: shaped amplitude expected %0d actual %0d",
                             $time, want.amp, m_shaped_amplitude);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("gaussian_formant_shaper verification failed");
            $finish;
        end
    end

    initial begin
        count_shadow = '0;
        foreach (word_shadow[k]) word_shadow[k] = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_passthrough();
        test_directed_extremes();
        test_ignored_writes();
        test_random_settings();
        test_full_rate();
        if (shaped_q.size() != 0) errors++;
        if (errors == 0) begin
            $display("gaussian_formant_shaper verification clean");
        end else begin
            $display("gaussian_formant_shaper verification failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/gfs_pkg.sv
rtl/gfs_formant.sv
rtl/gaussian_formant_shaper.sv
rtl/gfs_checker.sv
tb/sv/gaussian_formant_shaper_tb.sv
